[rtl/core/psp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CMD_W    = 15;
    localparam int IDX_W    = 2;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [IDX_W-1:0]    t_reg_idx;

    // Register indexes of the configuration port.
    localparam t_reg_idx REG_S1_HIGH = 2'd0;
    localparam t_reg_idx REG_S2_HIGH = 2'd1;
    localparam t_reg_idx REG_S1_LOW  = 2'd2;
    localparam t_reg_idx REG_S2_LOW  = 2'd3;

    localparam t_sample RST_S1_HIGH = 10'd1022;
    localparam t_sample RST_S2_HIGH = 10'd850;
    localparam t_sample RST_S1_LOW  = 10'd35;
    localparam t_sample RST_S2_LOW  = 10'd10;

    localparam t_cmd CMD_MAX = 15'd32767;

    typedef struct packed {
        t_sample s1_high;
        t_sample s2_high;
        t_sample s1_low;
        t_sample s2_low;
    } t_limits;

endpackage

`default_nettype wire

[rtl/core/pedal_sensor_plausibility_filter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Dual pedal sensor plausibility filter. Each input word carries one pair of
// 10-bit readings; the pair is rejected when sensor 1 reads below sensor 2 or
// either reading is at or beyond its high or low limit, and a rejected pair
// gives a zero command with the plausible flag clear while the average is
// left untouched. Accepted sensor 1 readings enter a moving average of
// AVG_WINDOW entries that starts from zeros after reset, so the command ramps
// up over the first AVG_WINDOW good pairs. The truncated mean is scaled by
// OUTPUT_FULL_SCALE / SENSOR_FULL_SCALE and saturated at the full scale (at
// most 32767). The block takes one word per clock unless all stages hold a
// word and the output is stalled; the window and running-sum update sets that
// rate. It stops taking words only when all six stages hold a word and the
// output is stalled.
module pedal_sensor_plausibility_filter_unit #(
    parameter int AVG_WINDOW        = 8,
    parameter int OUTPUT_FULL_SCALE = 32767,
    parameter int SENSOR_FULL_SCALE = 1023
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [23:0]          i_s_tdata,   // sample_one, sample_two
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [15:0]               o_m_tdata,   // drive_command
    output logic                      o_m_tuser,   // plausible
    input  wire logic                 i_cfg_we,
    input  wire psp_pkg::t_reg_idx    i_cfg_idx,
    input  wire psp_pkg::t_sample     i_cfg_wdata
);
    import psp_pkg::*;

    localparam int NSTG    = 6;
    localparam int SUM_W   = $clog2(AVG_WINDOW * 1023 + 1);
    // Division by the window length as a reciprocal multiply; exact because
    // the sum is below 2^SUM_W and the window length below 2^6.
    localparam int K_AVG   = SUM_W + 6;
    localparam logic [63:0] M_AVG_FULL =
        ((64'd1 << K_AVG) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW);
    localparam logic [K_AVG:0] M_AVG = M_AVG_FULL[K_AVG:0];
    localparam int PA_W    = SUM_W + K_AVG + 1;

    // mean * OFS / SFS = mean * Q + (mean * REM) / SFS
    localparam int P1_W    = SAMPLE_W + 16;
    localparam int P2_W    = 2 * SAMPLE_W;
    localparam logic [15:0] Q_SFS = 16'(OUTPUT_FULL_SCALE / SENSOR_FULL_SCALE);
    localparam t_sample REM_SFS   = SAMPLE_W'(OUTPUT_FULL_SCALE % SENSOR_FULL_SCALE);
    localparam int K_SFS   = P2_W + SAMPLE_W;
    localparam logic [63:0] M_SFS_FULL =
        ((64'd1 << K_SFS) + 64'(SENSOR_FULL_SCALE) - 64'd1) / 64'(SENSOR_FULL_SCALE);
    localparam logic [K_SFS:0] M_SFS = M_SFS_FULL[K_SFS:0];
    localparam int PS_W    = P2_W + K_SFS + 1;
    localparam int TOT_W   = P1_W + 1;
    localparam t_cmd LIMIT = (OUTPUT_FULL_SCALE > 32767) ? CMD_MAX
                                                          : CMD_W'(OUTPUT_FULL_SCALE);

    t_limits r_lim;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    t_sample r_in_a, r_in_b;
    t_sample r_win1 [AVG_WINDOW];
    logic [SUM_W-1:0] r_sum1, n_sum1;
    logic w_ok, w_win_we;

    logic [SUM_W-1:0] r_s1_sum;
    logic r_s1_ok;
    logic [PA_W-1:0] r_s2_prod;
    logic r_s2_ok;
    t_sample w_mean;
    logic [P1_W-1:0] r_s3_p1;
    logic [P2_W-1:0] r_s3_p2;
    logic r_s3_ok;
    logic [P1_W-1:0] r_s4_p1;
    logic [PS_W-1:0] r_s4_prod;
    logic r_s4_ok;
    logic [TOT_W-1:0] w_total;
    t_cmd w_cmd;
    t_cmd r_out_cmd;
    logic r_out_ok;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.s1_high <= RST_S1_HIGH;
            r_lim.s2_high <= RST_S2_HIGH;
            r_lim.s1_low  <= RST_S1_LOW;
            r_lim.s2_low  <= RST_S2_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_S1_HIGH: r_lim.s1_high <= i_cfg_wdata;
                REG_S2_HIGH: r_lim.s2_high <= i_cfg_wdata;
                REG_S1_LOW:  r_lim.s1_low  <= i_cfg_wdata;
                REG_S2_LOW:  r_lim.s2_low  <= i_cfg_wdata;
                default:     r_lim.s1_high <= r_lim.s1_high;
            endcase
        end
    end

    // A stage can load when it is empty or its word moves on this cycle.
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_in_a <= i_s_tdata[SAMPLE_W-1:0];
            r_in_b <= i_s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
    end

    assign w_ok = (r_in_a >= r_in_b)
               && (r_in_a < r_lim.s1_high) && (r_in_b < r_lim.s2_high)
               && (r_in_a > r_lim.s1_low)  && (r_in_b > r_lim.s2_low);

    // Sensor 2 readings only gate plausibility; they are not averaged.
    assign w_win_we = r_vld[0] && w_rdy[1] && w_ok;
    assign n_sum1   = r_sum1 - SUM_W'(r_win1[AVG_WINDOW-1]) + SUM_W'(r_in_a);

    // The oldest entry sits at the far end of the shift line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum1 <= '0;
            for (int k = 0; k < AVG_WINDOW; k++) begin
                r_win1[k] <= '0;
            end
        end else if (w_win_we) begin
            r_sum1    <= n_sum1;
            r_win1[0] <= r_in_a;
            for (int k = 1; k < AVG_WINDOW; k++) begin
                r_win1[k] <= r_win1[k-1];
            end
        end
    end

    assign w_mean  = r_s2_prod[K_AVG +: SAMPLE_W];
    assign w_total = TOT_W'(r_s4_p1) + TOT_W'(r_s4_prod[K_SFS +: SAMPLE_W]);
    assign w_cmd   = (w_total > TOT_W'(LIMIT)) ? LIMIT : w_total[CMD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_sum <= w_ok ? n_sum1 : r_sum1;
            r_s1_ok  <= w_ok;
        end
        if (w_rdy[2]) begin
            r_s2_prod <= PA_W'(r_s1_sum) * PA_W'(M_AVG);
            r_s2_ok   <= r_s1_ok;
        end
        if (w_rdy[3]) begin
            r_s3_p1 <= P1_W'(w_mean) * P1_W'(Q_SFS);
            r_s3_p2 <= P2_W'(w_mean) * P2_W'(REM_SFS);
            r_s3_ok <= r_s2_ok;
        end
        if (w_rdy[4]) begin
            r_s4_p1   <= r_s3_p1;
            r_s4_prod <= PS_W'(r_s3_p2) * PS_W'(M_SFS);
            r_s4_ok   <= r_s3_ok;
        end
        if (w_rdy[5]) begin
            r_out_cmd <= r_s4_ok ? w_cmd : '0;
            r_out_ok  <= r_s4_ok;
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {1'b0, r_out_cmd};
    assign o_m_tuser  = r_out_ok;

`ifndef SYNTHESIS
    a_sum_changes_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_sum1 != $past(r_sum1)) |-> $past(w_win_we))
        else $error("running sum changed without a window update");

    a_window_takes_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_win_we) |-> r_win1[0] == $past(r_in_a))
        else $error("window head does not hold the accepted sample");

    a_cmd_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] |-> r_out_cmd <= LIMIT)
        else $error("drive command above full scale");

    a_full_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !i_m_tready |-> !o_s_tready)
        else $error("input taken while the full pipeline is stalled");
`endif

endmodule

`default_nettype wire
